// ----- src/ess_pkg.sv -----
`timescale 1ns / 1ps

package ess_pkg;

  // Payload widths on the stream ports (fields packed up to whole bytes).
  localparam int InDataWidth  = 80;
  localparam int InFieldBits  = 79;
  localparam int OutDataWidth = 16;
  localparam int OutFieldBits = 12;

  // Configuration port.
  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 15;

  // Register values after reset.
  localparam logic signed [7:0] CabinSetpointReset = 8'sd22;
  localparam logic [4:0]        MaxTempExcessReset = 5'd5;
  localparam logic signed [8:0] EngineTempMinReset = 9'sd70;
  localparam logic signed [8:0] EngineTempMaxReset = 9'sd105;
  localparam logic [14:0]       MinBatteryMvReset  = 15'd12200;
  localparam logic [9:0]        MinSocReset        = 10'd700;
  localparam logic [9:0]        MaxTiltReset       = 10'd50;
  localparam logic [7:0]        RestartTimeoutReset = 8'd10;

  // Saturation value of the restart period counter.
  localparam logic [7:0] PeriodsMax = 8'd255;

  // Register indexes on the configuration port.
  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_CABIN_SETPOINT  = 3'd0,
    CFG_MAX_TEMP_EXCESS = 3'd1,
    CFG_ENGINE_TEMP_MIN = 3'd2,
    CFG_ENGINE_TEMP_MAX = 3'd3,
    CFG_MIN_BATTERY_MV  = 3'd4,
    CFG_MIN_SOC         = 3'd5,
    CFG_MAX_TILT        = 3'd6,
    CFG_RESTART_TIMEOUT = 3'd7
  } cfg_idx_t;

  // Restart command codes.
  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_RESTART = 2'd1,
    CMD_ABORT   = 2'd2
  } cmd_t;

  // Fault codes.
  typedef enum logic [1:0] {
    FAULT_NONE         = 2'd0,
    FAULT_LOW_BATTERY  = 2'd1,
    FAULT_BATTERY_DROP = 2'd2
  } fault_t;

  // Configuration register set.
  typedef struct packed {
    logic signed [7:0] cabin_setpoint;
    logic [4:0]        max_temp_excess;
    logic signed [8:0] engine_temp_min;
    logic signed [8:0] engine_temp_max;
    logic [14:0]       min_battery_mv;
    logic [9:0]        min_soc_tenths;
    logic [9:0]        max_tilt_tenths;
    logic [7:0]        restart_timeout;
  } cfg_t;

  // One vehicle sample, first field in the highest bits.
  typedef struct packed {
    logic signed [8:0] engine_temp;
    logic [14:0]       battery_mv;
    logic [9:0]        battery_soc;
    logic [9:0]        body_tilt;
    logic              door_ajar;
    logic signed [7:0] outside_temp;
    logic signed [7:0] cabin_temp;
    logic [2:0]        gear;
    logic              brake_pressed;
    logic              accel_pressed;
    logic [11:0]       speed;
    logic              enable;
  } item_t;

  // One result, first field in the highest bits.
  typedef struct packed {
    logic [5:0] condition_mask;
    fault_t     fault_code;
    logic       restart_busy;
    cmd_t       restart_command;
    logic       stop_active;
  } result_t;

endpackage

// ----- src/ess_cfg_regs.sv -----
`timescale 1ns / 1ps

module ess_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ess_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  logic [ess_pkg::CfgDataWidth-1:0]     cfg_data,
  output ess_pkg::cfg_t                        cfg
);

  ess_pkg::cfg_idx_t idx;

  // Writes are always taken.
  assign cfg_ready = 1'b1;
  assign idx       = ess_pkg::cfg_idx_t'(cfg_index);

  // Register file, each write keeps the low bits of the data word.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cabin_setpoint  <= ess_pkg::CabinSetpointReset;
      cfg.max_temp_excess <= ess_pkg::MaxTempExcessReset;
      cfg.engine_temp_min <= ess_pkg::EngineTempMinReset;
      cfg.engine_temp_max <= ess_pkg::EngineTempMaxReset;
      cfg.min_battery_mv  <= ess_pkg::MinBatteryMvReset;
      cfg.min_soc_tenths  <= ess_pkg::MinSocReset;
      cfg.max_tilt_tenths <= ess_pkg::MaxTiltReset;
      cfg.restart_timeout <= ess_pkg::RestartTimeoutReset;
    end else if (cfg_valid) begin
      case (idx)
        ess_pkg::CFG_CABIN_SETPOINT:  cfg.cabin_setpoint  <= cfg_data[7:0];
        ess_pkg::CFG_MAX_TEMP_EXCESS: cfg.max_temp_excess <= cfg_data[4:0];
        ess_pkg::CFG_ENGINE_TEMP_MIN: cfg.engine_temp_min <= cfg_data[8:0];
        ess_pkg::CFG_ENGINE_TEMP_MAX: cfg.engine_temp_max <= cfg_data[8:0];
        ess_pkg::CFG_MIN_BATTERY_MV:  cfg.min_battery_mv  <= cfg_data[14:0];
        ess_pkg::CFG_MIN_SOC:         cfg.min_soc_tenths  <= cfg_data[9:0];
        ess_pkg::CFG_MAX_TILT:        cfg.max_tilt_tenths <= cfg_data[9:0];
        ess_pkg::CFG_RESTART_TIMEOUT: cfg.restart_timeout <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- src/ess_core.sv -----
`timescale 1ns / 1ps

module ess_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  ess_pkg::item_t    item,
  input  ess_pkg::cfg_t     cfg,
  output ess_pkg::result_t  result
);

  // Controller state.
  logic       active_flag;
  logic       restarting_flag;
  logic       last_brake;
  logic       last_accel;
  logic [7:0] restart_periods;

  logic       active_flag_next;
  logic       restarting_flag_next;
  logic       last_brake_next;
  logic       last_accel_next;
  logic [7:0] restart_periods_next;

  logic signed [9:0] cabin_limit;
  logic signed [9:0] t_int_wide;
  logic c1, c2, c3, c4, c5, c6;
  logic trigger;
  logic battery_ok;
  logic busy_now;
  logic [7:0] periods_now;

  // Condition checks on the sample.
  always_comb begin
    cabin_limit = {{2{cfg.cabin_setpoint[7]}}, cfg.cabin_setpoint}
                + $signed({5'b0, cfg.max_temp_excess});
    t_int_wide  = {{2{item.cabin_temp[7]}}, item.cabin_temp};
    c1 = (item.speed == 12'd0) && !item.accel_pressed && item.brake_pressed
         && (item.gear == 3'd0);
    c2 = (t_int_wide <= cabin_limit) && (item.outside_temp <= cfg.cabin_setpoint);
    c3 = ((item.engine_temp >= cfg.engine_temp_min)
          && (item.engine_temp <= cfg.engine_temp_max)) || active_flag;
    c4 = (item.battery_soc >= cfg.min_soc_tenths)
         || (item.battery_mv > cfg.min_battery_mv);
    c5 = !item.door_ajar;
    c6 = item.body_tilt <= cfg.max_tilt_tenths;
    battery_ok = (item.battery_mv >= cfg.min_battery_mv)
                 && (item.battery_soc >= cfg.min_soc_tenths);
    trigger = active_flag && !restarting_flag
              && ((last_brake && !item.brake_pressed)
                  || (!last_accel && item.accel_pressed));
  end

  // Next state and result.
  always_comb begin
    active_flag_next     = active_flag;
    restarting_flag_next = restarting_flag;
    last_brake_next      = last_brake;
    last_accel_next      = last_accel;
    restart_periods_next = restart_periods;
    busy_now             = restarting_flag;
    periods_now          = restart_periods;

    result.stop_active     = active_flag;
    result.restart_command = ess_pkg::CMD_NONE;
    result.restart_busy    = restarting_flag;
    result.fault_code      = ess_pkg::FAULT_NONE;
    result.condition_mask  = 6'd0;

    if (item.enable) begin
      result.condition_mask = {c6, c5, c4, c3, c2, c1};
      active_flag_next      = c1 && c2 && c3 && c4 && c5 && c6;
      last_brake_next       = item.brake_pressed;
      last_accel_next       = item.accel_pressed;

      // Pedal event while active starts a restart or flags a weak battery.
      if (trigger) begin
        if (battery_ok) begin
          result.restart_command = ess_pkg::CMD_RESTART;
          busy_now               = 1'b1;
          periods_now            = 8'd0;
        end else begin
          result.fault_code = ess_pkg::FAULT_LOW_BATTERY;
        end
      end

      // Restart in progress: finish on timeout, abort on voltage drop.
      restarting_flag_next = busy_now;
      restart_periods_next = periods_now;
      if (busy_now) begin
        if (periods_now >= cfg.restart_timeout) begin
          restarting_flag_next = 1'b0;
        end else if (item.battery_mv < cfg.min_battery_mv) begin
          result.restart_command = ess_pkg::CMD_ABORT;
          result.fault_code      = ess_pkg::FAULT_BATTERY_DROP;
          restarting_flag_next   = 1'b0;
        end else if (periods_now < ess_pkg::PeriodsMax) begin
          restart_periods_next = periods_now + 8'd1;
        end
      end

      result.stop_active  = active_flag_next;
      result.restart_busy = restarting_flag_next;
    end
  end

  // State update once per processed sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_flag     <= 1'b0;
      restarting_flag <= 1'b0;
      last_brake      <= 1'b0;
      last_accel      <= 1'b0;
      restart_periods <= 8'd0;
    end else if (step) begin
      active_flag     <= active_flag_next;
      restarting_flag <= restarting_flag_next;
      last_brake      <= last_brake_next;
      last_accel      <= last_accel_next;
      restart_periods <= restart_periods_next;
    end
  end

endmodule

// ----- src/engine_stop_start_controller.sv -----
`timescale 1ns / 1ps

// Engine stop-start controller.
// One vehicle sample enters on the s_ stream per control period; each sample
// gives exactly one result on the m_ stream (active flag, restart command,
// restart busy, fault code and the six condition bits).
// Limits are set through the cfg write channel (index 0..7, data in the low
// bits); cfg_ready is always high. Write them only while no sample is in
// flight.
// An accepted sample is registered in the input stage; its result is then
// registered in the result stage and shown on m_tvalid. Throughput is one
// sample per cycle while the receiver keeps m_tready high: a registered input
// stage and a registered result stage surround a single pass of compare
// logic, and the controller state updates in that pass.
// When the receiver holds m_tready low, the result stays put and the input
// stage still takes one more sample; after that s_tready drops until the
// result is taken.
// Synchronous reset empties both stages, clears all flags and counters and
// loads the default limits.
module engine_stop_start_controller (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // enable, speed, accel_pressed, brake_pressed, gear, cabin_temp,
  // outside_temp, door_ajar, body_tilt, battery_soc, battery_mv, engine_temp
  input  logic [ess_pkg::InDataWidth-1:0]       s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // stop_active, restart_command, restart_busy, fault_code, condition_mask
  output logic [ess_pkg::OutDataWidth-1:0]      m_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ess_pkg::CfgIndexWidth-1:0]     cfg_index,
  input  logic [ess_pkg::CfgDataWidth-1:0]      cfg_data
);

  ess_pkg::cfg_t    cfg;
  ess_pkg::item_t   item_q;
  ess_pkg::result_t result;
  ess_pkg::result_t result_q;
  logic             item_valid;
  logic             advance;

  ess_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ess_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (item_q),
    .cfg    (cfg),
    .result (result)
  );

  // The held sample moves on whenever the result stage is free or drains.
  assign advance  = item_valid && (!m_tvalid || m_tready);
  assign s_tready = !item_valid || advance;

  // Input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_q <= ess_pkg::item_t'(s_tdata[ess_pkg::InFieldBits-1:0]);
    end
  end

  // Result stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= result;
    end
  end

  assign m_tdata = {{(ess_pkg::OutDataWidth - ess_pkg::OutFieldBits){1'b0}}, result_q};

endmodule

// ----- src/ess_checker.sv -----
`timescale 1ns / 1ps

module ess_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  s_tvalid,
  input logic                                  s_tready,
  input logic                                  m_tvalid,
  input logic                                  m_tready,
  input logic [ess_pkg::OutDataWidth-1:0]      m_tdata
);

  ess_pkg::result_t res;

  assign res = ess_pkg::result_t'(m_tdata[ess_pkg::OutFieldBits-1:0]);

  // A stalled result keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // A new result traces back to a request accepted on the input side.
  a_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without a matching request");

  // The input side only stalls when both stages are full and blocked.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without downstream stall");

  // An abort always reports the battery drop and ends the restart.
  a_abort: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (res.restart_command == ess_pkg::CMD_ABORT) |->
      (res.fault_code == ess_pkg::FAULT_BATTERY_DROP) && !res.restart_busy)
    else $error("abort without battery drop fault");

endmodule

bind engine_stop_start_controller ess_checker u_ess_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- sim/ess_result_checker.sv -----
`timescale 1ns / 1ps

// Watches the sample, result and limit channels of the stop-start controller.
// It keeps its own copy of the limits and controller state, works out the
// result of every accepted sample and compares each accepted result with the
// oldest one due.
module ess_result_checker
  import ess_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  input  logic                     s_tready,
  input  logic [InDataWidth-1:0]   s_tdata,
  input  logic                     m_tvalid,
  input  logic                     m_tready,
  input  logic [OutDataWidth-1:0]  m_tdata,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data,
  output int                       pending,
  output int                       mismatches
);

  // Limits and controller state as the block should hold them.
  cfg_t       lim;
  logic       active_now;
  logic       restarting_now;
  logic       brake_seen;
  logic       accel_seen;
  logic [7:0] restart_count;

  result_t results_due[$];
  int      n_samples;
  int      n_results;

  assign pending = n_samples - n_results;

  // Advances the controller state by one sample and returns its result.
  function automatic result_t controller_step(input item_t it);
    result_t r;
    int      t_int;
    int      t_ext;
    int      t_eng;
    int      setpoint;
    logic    prev_active;
    logic    c_pedals;
    logic    c_cabin;
    logic    c_engine;
    logic    c_battery;
    logic    c_doors;
    logic    c_tilt;
    logic    released;
    logic    pressed;
    r = '0;
    r.restart_command = CMD_NONE;
    r.fault_code = FAULT_NONE;
    if (it.enable) begin
      t_int = int'($signed(it.cabin_temp));
      t_ext = int'($signed(it.outside_temp));
      t_eng = int'($signed(it.engine_temp));
      setpoint = int'($signed(lim.cabin_setpoint));
      prev_active = active_now;

      // The six stop conditions; engine temperature is waived while active.
      c_pedals = (it.speed == '0) && !it.accel_pressed && it.brake_pressed &&
                 (it.gear == '0);
      c_cabin = (t_int <= setpoint + int'(lim.max_temp_excess)) && (t_ext <= setpoint);
      c_engine = (t_eng >= int'($signed(lim.engine_temp_min)) &&
                  t_eng <= int'($signed(lim.engine_temp_max))) || prev_active;
      c_battery = (it.battery_soc >= lim.min_soc_tenths) ||
                  (it.battery_mv > lim.min_battery_mv);
      c_doors = !it.door_ajar;
      c_tilt = it.body_tilt <= lim.max_tilt_tenths;
      r.condition_mask = {c_tilt, c_doors, c_battery, c_engine, c_cabin, c_pedals};
      active_now = c_pedals && c_cabin && c_engine && c_battery && c_doors && c_tilt;

      // A pedal edge after a stop asks for a restart if the battery allows it.
      if (prev_active && !restarting_now) begin
        released = brake_seen && !it.brake_pressed;
        pressed = !accel_seen && it.accel_pressed;
        if (released || pressed) begin
          if (it.battery_mv >= lim.min_battery_mv &&
              it.battery_soc >= lim.min_soc_tenths) begin
            r.restart_command = CMD_RESTART;
            restarting_now = 1'b1;
            restart_count = '0;
          end else begin
            r.fault_code = FAULT_LOW_BATTERY;
          end
        end
      end
      brake_seen = it.brake_pressed;
      accel_seen = it.accel_pressed;

      // A running restart either times out, aborts on a voltage drop or counts on.
      if (restarting_now) begin
        if (restart_count >= lim.restart_timeout) begin
          restarting_now = 1'b0;
        end else if (it.battery_mv < lim.min_battery_mv) begin
          r.restart_command = CMD_ABORT;
          r.fault_code = FAULT_BATTERY_DROP;
          restarting_now = 1'b0;
        end else if (restart_count < PeriodsMax) begin
          restart_count = restart_count + 8'd1;
        end
      end
    end
    r.stop_active = active_now;
    r.restart_busy = restarting_now;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t seen;
    result_t want;
    if (rst) begin
      lim.cabin_setpoint = CabinSetpointReset;
      lim.max_temp_excess = MaxTempExcessReset;
      lim.engine_temp_min = EngineTempMinReset;
      lim.engine_temp_max = EngineTempMaxReset;
      lim.min_battery_mv = MinBatteryMvReset;
      lim.min_soc_tenths = MinSocReset;
      lim.max_tilt_tenths = MaxTiltReset;
      lim.restart_timeout = RestartTimeoutReset;
      active_now = 1'b0;
      restarting_now = 1'b0;
      brake_seen = 1'b0;
      accel_seen = 1'b0;
      restart_count = '0;
      results_due.delete();
      mismatches = 0;
      n_samples <= 0;
      n_results <= 0;
    end else begin
      // Limit writes take effect for every later sample.
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_CABIN_SETPOINT:  lim.cabin_setpoint = cfg_data[7:0];
          CFG_MAX_TEMP_EXCESS: lim.max_temp_excess = cfg_data[4:0];
          CFG_ENGINE_TEMP_MIN: lim.engine_temp_min = cfg_data[8:0];
          CFG_ENGINE_TEMP_MAX: lim.engine_temp_max = cfg_data[8:0];
          CFG_MIN_BATTERY_MV:  lim.min_battery_mv = cfg_data[14:0];
          CFG_MIN_SOC:         lim.min_soc_tenths = cfg_data[9:0];
          CFG_MAX_TILT:        lim.max_tilt_tenths = cfg_data[9:0];
          CFG_RESTART_TIMEOUT: lim.restart_timeout = cfg_data[7:0];
          default: ;
        endcase
      end

      // Compare an accepted result with the oldest one due.
      if (m_tvalid && m_tready) begin
        seen = result_t'(m_tdata[OutFieldBits-1:0]);
        if (results_due.size() == 0) begin
          $error("result %h arrived with no result due", m_tdata);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          n_results <= n_results + 1;
          if (seen.stop_active !== want.stop_active) begin
            $error("stop_active expected %0d actual %0d", want.stop_active, seen.stop_active);
            mismatches++;
          end
          if (seen.restart_command !== want.restart_command) begin
            $error("restart_command expected %0d actual %0d",
                   want.restart_command, seen.restart_command);
            mismatches++;
          end
          if (seen.restart_busy !== want.restart_busy) begin
            $error("restart_busy expected %0d actual %0d", want.restart_busy,
                   seen.restart_busy);
            mismatches++;
          end
          if (seen.fault_code !== want.fault_code) begin
            $error("fault_code expected %0d actual %0d", want.fault_code, seen.fault_code);
            mismatches++;
          end
          if (seen.condition_mask !== want.condition_mask) begin
            $error("condition_mask expected %0d actual %0d", want.condition_mask,
                   seen.condition_mask);
            mismatches++;
          end
        end
      end

      // Every accepted sample makes exactly one result.
      if (s_tvalid && s_tready) begin
        results_due.push_back(controller_step(item_t'(s_tdata[InFieldBits-1:0])));
        n_samples <= n_samples + 1;
      end
    end
  end

endmodule

// ----- sim/engine_stop_start_controller_tb.sv -----
`timescale 1ns / 1ps

module engine_stop_start_controller_tb;
  import ess_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int LongHold   = 60;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  // enable, speed, accel_pressed, brake_pressed, gear, cabin_temp,
  // outside_temp, door_ajar, body_tilt, battery_soc, battery_mv, engine_temp
  logic [InDataWidth-1:0]   s_tdata = '0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  // stop_active, restart_command, restart_busy, fault_code, condition_mask
  logic [OutDataWidth-1:0]  m_tdata;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0]  cfg_data = '0;

  int pending;
  int mismatches;

  // Stimulus knobs shared with the result sink.
  bit   src_idle_on = 1'b1;
  bit   sink_idle_on = 1'b1;
  bit   long_hold_req = 1'b0;
  bit   tail = 1'b0;
  cfg_t lim_now;
  int   sent = 0;

  engine_stop_start_controller dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  ess_result_checker checker_i (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pending(pending),
    .mismatches(mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // Result sink: random stall bursts, plus one long hold when asked for.
  initial begin : sink
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        m_tready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        long_hold_req = 1'b0;
        m_tready <= 1'b1;
      end else if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 9) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic int pick(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int clip(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int near(input int base, input int spread);
    return base + pick(-spread, spread);
  endfunction

  function automatic int cabin_ceiling();
    return clip(int'($signed(lim_now.cabin_setpoint)) + int'(lim_now.max_temp_excess),
                -128, 127);
  endfunction

  // Any bit pattern at all, enable mostly high.
  function automatic item_t noise_sample();
    item_t it;
    it = item_t'(InFieldBits'({$urandom(), $urandom(), $urandom()}));
    it.enable = pick(0, 4) != 0;
    return it;
  endfunction

  // Meets every stop condition under the current limits unless engine min > max.
  function automatic item_t parked_sample();
    item_t it;
    int    eng_lo;
    int    eng_hi;
    it = '0;
    it.enable = 1'b1;
    it.brake_pressed = 1'b1;
    it.cabin_temp = 8'(clip(cabin_ceiling() - pick(0, 15), -128, 127));
    it.outside_temp = 8'(clip(int'($signed(lim_now.cabin_setpoint)) - pick(0, 15),
                              -128, 127));
    eng_lo = int'($signed(lim_now.engine_temp_min));
    eng_hi = int'($signed(lim_now.engine_temp_max));
    it.engine_temp = 9'((eng_lo <= eng_hi) ? pick(eng_lo, eng_hi) : pick(-256, 255));
    it.battery_soc = 10'(clip(int'(lim_now.min_soc_tenths) + pick(0, 60), 0, 1023));
    it.battery_mv = 15'(clip(int'(lim_now.min_battery_mv) + pick(1, 900), 0, 32767));
    it.body_tilt = 10'(clip(int'(lim_now.max_tilt_tenths) - pick(0, 30), 0, 1023));
    return it;
  endfunction

  // Pushes one condition of a parked sample onto or just past its limit.
  function automatic item_t nudge(input item_t it);
    case (pick(0, 9))
      0: it.speed = 12'(pick(0, 2));
      1: it.accel_pressed = 1'b1;
      2: it.brake_pressed = 1'b0;
      3: it.gear = 3'(pick(0, 7));
      4: it.cabin_temp = 8'(near(cabin_ceiling(), 1));
      5: it.outside_temp = 8'(near(int'($signed(lim_now.cabin_setpoint)), 1));
      6: it.engine_temp = 9'(pick(0, 1) ? near(int'($signed(lim_now.engine_temp_min)), 1)
                                        : near(int'($signed(lim_now.engine_temp_max)), 1));
      7: begin
        it.battery_soc = 10'(near(int'(lim_now.min_soc_tenths), 1));
        it.battery_mv = 15'(near(int'(lim_now.min_battery_mv), 1));
      end
      8: it.door_ajar = 1'b1;
      default: it.body_tilt = 10'(near(int'(lim_now.max_tilt_tenths), 1));
    endcase
    return it;
  endfunction

  // Brake release and/or accelerator press after a stop; battery sometimes marginal.
  function automatic item_t trigger_sample();
    item_t it;
    it = parked_sample();
    case (pick(0, 2))
      0: it.brake_pressed = 1'b0;
      1: it.accel_pressed = 1'b1;
      default: begin
        it.brake_pressed = 1'b0;
        it.accel_pressed = 1'b1;
      end
    endcase
    if (pick(0, 3) == 0) begin
      it.battery_soc = 10'(near(int'(lim_now.min_soc_tenths), 2));
      it.battery_mv = 15'(near(int'(lim_now.min_battery_mv), 2));
    end
    return it;
  endfunction

  // Samples while the engine restarts; the voltage now and then sags.
  function automatic item_t restart_sample();
    item_t it;
    it = (pick(0, 3) == 0) ? noise_sample() : parked_sample();
    it.brake_pressed = 1'(pick(0, 1));
    it.accel_pressed = 1'(pick(0, 1));
    if (pick(0, 7) == 0)
      it.battery_mv = 15'(near(int'(lim_now.min_battery_mv), 3));
    else
      it.battery_mv = 15'(clip(int'(lim_now.min_battery_mv) + pick(0, 1500), 0, 32767));
    return it;
  endfunction

  // Offers one sample until it is taken, then maybe leaves a gap.
  task automatic feed(input item_t it);
    s_tdata <= InDataWidth'(it);
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    if (it.enable)
      sent++;
    if (src_idle_on && pick(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat (pick(1, 9)) @(posedge clk);
    end
  endtask

  // Stops offering samples until every result due has been taken.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataWidth-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Loads a full limit set once the controller has gone quiet.
  task automatic apply_limits(input cfg_t c);
    drain();
    write_reg(CFG_CABIN_SETPOINT, CfgDataWidth'($signed(c.cabin_setpoint)));
    write_reg(CFG_MAX_TEMP_EXCESS, CfgDataWidth'(c.max_temp_excess));
    write_reg(CFG_ENGINE_TEMP_MIN, CfgDataWidth'($signed(c.engine_temp_min)));
    write_reg(CFG_ENGINE_TEMP_MAX, CfgDataWidth'($signed(c.engine_temp_max)));
    write_reg(CFG_MIN_BATTERY_MV, CfgDataWidth'(c.min_battery_mv));
    write_reg(CFG_MIN_SOC, CfgDataWidth'(c.min_soc_tenths));
    write_reg(CFG_MAX_TILT, CfgDataWidth'(c.max_tilt_tenths));
    write_reg(CFG_RESTART_TIMEOUT, CfgDataWidth'(c.restart_timeout));
    cfg_valid <= 1'b0;
    lim_now = c;
  endtask

  function automatic cfg_t random_limits();
    cfg_t c;
    int   eng_lo;
    eng_lo = pick(-40, 120);
    c.cabin_setpoint = 8'(pick(-40, 85));
    c.max_temp_excess = 5'(pick(0, 31));
    c.engine_temp_min = 9'(eng_lo);
    c.engine_temp_max = 9'(eng_lo + pick(0, 80));
    c.min_battery_mv = 15'(pick(0, 20000));
    c.min_soc_tenths = 10'(pick(0, 1000));
    c.max_tilt_tenths = 10'(pick(0, 900));
    c.restart_timeout = 8'(pick(1, 20));
    return c;
  endfunction

  // A stop followed by a pedal edge and some restart periods.
  task automatic stop_and_go();
    repeat (pick(1, 4))
      feed((pick(0, 4) == 0) ? nudge(parked_sample()) : parked_sample());
    feed(trigger_sample());
    repeat (pick(0, 14))
      feed(restart_sample());
  endtask

  // Mostly stop-and-go sequences with bursts of arbitrary samples in between.
  task automatic random_traffic(input int count);
    int target;
    target = sent + count;
    while (sent < target) begin
      if (!tail && pick(0, 30) == 0)
        src_idle_on = !src_idle_on;
      if (!tail && pick(0, 30) == 0)
        sink_idle_on = !sink_idle_on;
      if (pick(0, 4) == 0)
        repeat (pick(1, 4)) feed(noise_sample());
      else
        stop_and_go();
    end
  endtask

  initial begin : stimulus
    item_t it;
    cfg_t  c;

    lim_now.cabin_setpoint = CabinSetpointReset;
    lim_now.max_temp_excess = MaxTempExcessReset;
    lim_now.engine_temp_min = EngineTempMinReset;
    lim_now.engine_temp_max = EngineTempMaxReset;
    lim_now.min_battery_mv = MinBatteryMvReset;
    lim_now.min_soc_tenths = MinSocReset;
    lim_now.max_tilt_tenths = MaxTiltReset;
    lim_now.restart_timeout = RestartTimeoutReset;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed samples under the reset limits: a disabled sample, all-zero and
    // all-one fields, a stop held through an engine temperature out of range,
    // a full restart to its timeout, a low-battery fault and a voltage abort.
    it = '1;
    it.enable = 1'b0;
    feed(it);
    it = '0;
    it.enable = 1'b1;
    feed(it);
    feed('1);
    repeat (3) feed(parked_sample());
    it = parked_sample();
    it.engine_temp = 9'sd200;
    feed(it);
    it = parked_sample();
    it.brake_pressed = 1'b0;
    it.battery_mv = 15'd14000;
    it.battery_soc = 10'd900;
    feed(it);
    repeat (10) feed(parked_sample());
    it = parked_sample();
    it.accel_pressed = 1'b1;
    it.battery_mv = 15'd11000;
    it.battery_soc = 10'd100;
    feed(it);
    repeat (2) feed(parked_sample());
    it = parked_sample();
    it.brake_pressed = 1'b0;
    feed(it);
    it = parked_sample();
    it.battery_mv = 15'd11000;
    feed(it);

    // Reset limits, with one full drain half way.
    random_traffic(150);
    drain();
    random_traffic(150);

    // Random limits; the sink holds off for a long stretch meanwhile.
    apply_limits(random_limits());
    random_traffic(100);
    long_hold_req = 1'b1;
    random_traffic(200);

    // Lowest limits.
    c.cabin_setpoint = -8'sd40;
    c.max_temp_excess = 5'd0;
    c.engine_temp_min = -9'sd40;
    c.engine_temp_max = -9'sd40;
    c.min_battery_mv = 15'd0;
    c.min_soc_tenths = 10'd0;
    c.max_tilt_tenths = 10'd0;
    c.restart_timeout = 8'd1;
    apply_limits(c);
    random_traffic(250);

    // Highest limits.
    c.cabin_setpoint = 8'sd85;
    c.max_temp_excess = 5'd31;
    c.engine_temp_min = 9'sd200;
    c.engine_temp_max = 9'sd200;
    c.min_battery_mv = 15'd20000;
    c.min_soc_tenths = 10'd1000;
    c.max_tilt_tenths = 10'd900;
    c.restart_timeout = 8'd255;
    apply_limits(c);
    random_traffic(250);

    // Zero timeout ends a restart on its first period; engine window inverted.
    c = random_limits();
    c.restart_timeout = 8'd0;
    c.engine_temp_min = 9'sd150;
    c.engine_temp_max = 9'sd60;
    apply_limits(c);
    random_traffic(100);

    // Back to sensible limits, finishing at full rate on both sides.
    apply_limits(random_limits());
    random_traffic(150);
    tail = 1'b1;
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    random_traffic(150);

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ----- files.f -----
src/ess_pkg.sv
src/ess_cfg_regs.sv
src/ess_core.sv
src/engine_stop_start_controller.sv
src/ess_checker.sv
sim/ess_result_checker.sv
sim/engine_stop_start_controller_tb.sv
